### hdl/sticky_taken_branch_predictor_macros.svh
// ----------------------------------------------------------------------------
// Sticky-taken branch predictor: assertion macros
// Shared macros for the concurrent checks on the predictor ports.
// ----------------------------------------------------------------------------
`ifndef STICKY_TAKEN_BRANCH_PREDICTOR_MACROS_SVH
`define STICKY_TAKEN_BRANCH_PREDICTOR_MACROS_SVH

// Clocked property, disabled while reset is held.
`define STBP_CHECK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Condition that must hold at every clock edge while reset is not held.
`define STBP_ALWAYS(lbl, cond, msg) \
    `STBP_CHECK(lbl, (1'b1 |-> (cond)), msg)

`endif

### hdl/stbp_pkg.sv
// ----------------------------------------------------------------------------
// Sticky-taken branch predictor: package
// Sizes, reset values and the types passed along the chain of table cells.
// ----------------------------------------------------------------------------
package stbp_pkg;

    // Table depth and the address bits that take part in the comparison.
    localparam int TABLE_ENTRIES = 64;
    localparam int ADDRESS_BITS  = 48;

    // Fixed field widths of the ports.
    localparam int IN_W       = 48;
    localparam int KEY_W      = (ADDRESS_BITS < IN_W) ? ADDRESS_BITS : IN_W;
    localparam int WINDOW_W   = 16;
    localparam int COUNT_W    = 32;
    localparam int RESULT_W   = 3 + 3 * COUNT_W;
    localparam int OUT_DATA_W = ((RESULT_W + 7) / 8) * 8;

    localparam logic [WINDOW_W-1:0] WINDOW_RESET = WINDOW_W'(15);
    localparam logic [COUNT_W-1:0]  COUNT_MAX    = {COUNT_W{1'b1}};

    typedef logic [KEY_W-1:0] t_key;

    // Search wave that travels from cell to cell, one cell per cycle.
    typedef struct packed {
        logic tok;
        logic hit_cur;
        logic hit_prev;
    } t_wave;

    // One table entry, shifted toward the tail on insertion.
    typedef struct packed {
        logic valid;
        t_key addr;
    } t_entry;

endpackage

### hdl/stbp_cell.sv
// ----------------------------------------------------------------------------
// Sticky-taken branch predictor: table cell
// Holds one taken-source entry, checks the passing search wave against it and
// shifts its entry to the next cell when a new source is inserted.
// ----------------------------------------------------------------------------
module stbp_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  stbp_pkg::t_key  i_key_cur,
    input  stbp_pkg::t_key  i_key_prev,
    input  stbp_pkg::t_wave i_wave,
    output stbp_pkg::t_wave o_wave,
    input  logic            i_shift,
    input  stbp_pkg::t_entry i_entry,
    output stbp_pkg::t_entry o_entry
);

    logic            r_valid;
    stbp_pkg::t_key  r_addr;
    stbp_pkg::t_wave r_wave;
    stbp_pkg::t_wave n_wave;
    logic            w_match_cur;
    logic            w_match_prev;

    // Compare both search keys against the stored entry.
    assign w_match_cur  = r_valid && (r_addr == i_key_cur);
    assign w_match_prev = r_valid && (r_addr == i_key_prev);

    // Fold this cell's matches into the wave as it passes.
    always_comb begin
        n_wave.tok      = i_wave.tok;
        n_wave.hit_cur  = i_wave.tok & (i_wave.hit_cur | w_match_cur);
        n_wave.hit_prev = i_wave.tok & (i_wave.hit_prev | w_match_prev);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wave <= '0;
        end else begin
            r_wave <= n_wave;
        end
    end

    // Valid bit is cleared by reset; the address is plain payload.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_shift) begin
            r_valid <= i_entry.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_addr <= i_entry.addr;
        end
    end

    assign o_wave        = r_wave;
    assign o_entry.valid = r_valid;
    assign o_entry.addr  = r_addr;

endmodule

### hdl/sticky_taken_branch_predictor.sv
// ----------------------------------------------------------------------------
// Sticky-taken branch predictor: top level
// Judges each step of an address trace as taken or sequential, predicts it
// from a table of earlier taken sources and keeps saturating counters.
//
// Channel   Direction  Payload
// s_axis    in         tdata[47:0] trace_address
// m_axis    out        tdata: was_taken, predicted_taken, prediction_correct,
//                      correct_total, taken_total, judged_total
// cfg       in         i_cfg_wdata: forward_window, written when i_cfg_we
//
// After the first, each item is searched and committed before the next is
// accepted; the search wave crosses the cell chain one cell per cycle.
// The first item after reset only stores its address.
// Reset is synchronous and clears every table valid bit at once.
// An unread result stalls the commit, and no new item is accepted until it is done.
// ----------------------------------------------------------------------------
module sticky_taken_branch_predictor (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [47:0] trace_address
    input  logic [stbp_pkg::IN_W-1:0]       s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [0] was_taken, [1] predicted_taken, [2] prediction_correct,
    // [34:3] correct_total, [66:35] taken_total, [98:67] judged_total, rest 0
    output logic [stbp_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                            i_cfg_we,
    input  logic [stbp_pkg::WINDOW_W-1:0]   i_cfg_wdata
);

    localparam int N = stbp_pkg::TABLE_ENTRIES;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_START  = 2'd1;
    localparam logic [1:0] ST_SEARCH = 2'd2;
    localparam logic [1:0] ST_COMMIT = 2'd3;

    logic [1:0]                        r_state;
    logic [stbp_pkg::WINDOW_W-1:0]     r_window;
    logic                              r_have;
    stbp_pkg::t_key                    r_prev;
    stbp_pkg::t_key                    r_cur;
    logic                              r_pending;
    logic                              r_taken;
    logic                              r_hit_cur;
    logic                              r_hit_prev;
    logic [stbp_pkg::COUNT_W-1:0]      r_correct;
    logic [stbp_pkg::COUNT_W-1:0]      r_taken_cnt;
    logic [stbp_pkg::COUNT_W-1:0]      r_judged;
    logic                              r_out_valid;
    logic [stbp_pkg::OUT_DATA_W-1:0]   r_out_data;

    logic [stbp_pkg::COUNT_W-1:0]      n_correct;
    logic [stbp_pkg::COUNT_W-1:0]      n_taken_cnt;
    logic [stbp_pkg::COUNT_W-1:0]      n_judged;

    logic                              w_accept;
    logic                              w_commit;
    logic                              w_right;
    logic                              w_shift;
    logic                              w_far;
    stbp_pkg::t_key                    w_diff;
    stbp_pkg::t_key                    w_in_key;

    stbp_pkg::t_wave                   w_wave  [0:N];
    stbp_pkg::t_entry                  w_entry [0:N];

    assign w_in_key      = s_axis_tdata[stbp_pkg::KEY_W-1:0];
    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_commit      = (r_state == ST_COMMIT) && (!r_out_valid || m_axis_tready);
    assign w_right       = (r_pending == r_taken);
    assign w_shift       = w_commit && r_taken && !r_hit_prev;

    // Step classification: backward, or forward beyond the window.
    assign w_diff = r_cur - r_prev;
    assign w_far  = (r_cur < r_prev) || (w_diff > stbp_pkg::KEY_W'(r_window));

    // Saturating counter updates for the item being committed.
    always_comb begin
        n_correct   = r_correct;
        n_taken_cnt = r_taken_cnt;
        n_judged    = r_judged;
        if (w_right && (r_correct != stbp_pkg::COUNT_MAX)) begin
            n_correct = r_correct + 1'b1;
        end
        if (r_taken && (r_taken_cnt != stbp_pkg::COUNT_MAX)) begin
            n_taken_cnt = r_taken_cnt + 1'b1;
        end
        if (r_judged != stbp_pkg::COUNT_MAX) begin
            n_judged = r_judged + 1'b1;
        end
    end

    // Head of the chain: the wave starts empty, the new source enters valid.
    always_comb begin
        w_wave[0].tok      = (r_state == ST_START);
        w_wave[0].hit_cur  = 1'b0;
        w_wave[0].hit_prev = 1'b0;
        w_entry[0].valid   = 1'b1;
        w_entry[0].addr    = r_prev;
    end

    // Row of table cells, oldest entry at the tail.
    for (genvar g = 0; g < N; g++) begin : g_cell
        stbp_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_key_cur  (r_cur),
            .i_key_prev (r_prev),
            .i_wave     (w_wave[g]),
            .o_wave     (w_wave[g+1]),
            .i_shift    (w_shift),
            .i_entry    (w_entry[g]),
            .o_entry    (w_entry[g+1])
        );
    end

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= stbp_pkg::WINDOW_RESET;
        end else if (i_cfg_we) begin
            r_window <= i_cfg_wdata;
        end
    end

    // Sequencer and architectural state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_have      <= 1'b0;
            r_prev      <= '0;
            r_pending   <= 1'b0;
            r_correct   <= '0;
            r_taken_cnt <= '0;
            r_judged    <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        if (!r_have) begin
                            r_have    <= 1'b1;
                            r_prev    <= w_in_key;
                            r_pending <= 1'b0;
                        end else begin
                            r_state <= ST_START;
                        end
                    end
                end
                ST_START: begin
                    r_state <= ST_SEARCH;
                end
                ST_SEARCH: begin
                    if (w_wave[N].tok) begin
                        r_state <= ST_COMMIT;
                    end
                end
                ST_COMMIT: begin
                    if (w_commit) begin
                        r_pending   <= r_hit_cur;
                        r_prev      <= r_cur;
                        r_correct   <= n_correct;
                        r_taken_cnt <= n_taken_cnt;
                        r_judged    <= n_judged;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Per-item working registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cur <= w_in_key;
        end
        if (r_state == ST_START) begin
            r_taken <= w_far;
        end
        if ((r_state == ST_SEARCH) && w_wave[N].tok) begin
            r_hit_cur  <= w_wave[N].hit_cur;
            r_hit_prev <= w_wave[N].hit_prev;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_commit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_out_data <= stbp_pkg::OUT_DATA_W'({n_judged, n_taken_cnt, n_correct,
                                                 w_right, r_pending, r_taken});
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

### hdl/stbp_checker.sv
// ----------------------------------------------------------------------------
// Sticky-taken branch predictor: port checker
// Checks the result stream seen on the top-level ports over time.
// ----------------------------------------------------------------------------
`include "sticky_taken_branch_predictor_macros.svh"

module stbp_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic [stbp_pkg::IN_W-1:0]       s_axis_tdata,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [stbp_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input logic                            i_cfg_we,
    input logic [stbp_pkg::WINDOW_W-1:0]   i_cfg_wdata
);

    localparam int CW = stbp_pkg::COUNT_W;

    logic [CW-1:0] w_correct_total;
    logic [CW-1:0] w_taken_total;
    logic [CW-1:0] w_judged_total;

    assign w_correct_total = m_axis_tdata[3+CW-1:3];
    assign w_taken_total   = m_axis_tdata[3+2*CW-1:3+CW];
    assign w_judged_total  = m_axis_tdata[3+3*CW-1:3+2*CW];

    // A stalled item keeps its payload.
    `STBP_CHECK(a_out_hold, (m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)), "result changed while stalled")

    // The correct flag agrees with the outcome and the prediction.
    `STBP_ALWAYS(a_correct_flag, (!m_axis_tvalid || (m_axis_tdata[2] == (m_axis_tdata[0] == m_axis_tdata[1]))), "prediction_correct mismatch")

    // Partial counts never exceed the number of judged steps.
    `STBP_ALWAYS(a_count_order, (!m_axis_tvalid || ((w_correct_total <= w_judged_total) && (w_taken_total <= w_judged_total))), "counter exceeds judged_total")

    // A taken step has been counted.
    `STBP_ALWAYS(a_taken_counted, (!m_axis_tvalid || !m_axis_tdata[0] || (w_taken_total != '0)), "taken step not counted")

endmodule

bind sticky_taken_branch_predictor stbp_checker u_stbp_checker (.*);
